>>> rtl/core/fisn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisn_pkg
// shared types, constants and float helpers for the inverse-sqrt root block
// ----------------------------------------------------------------------------
package fisn_pkg;

	localparam int NEWTON_STEPS = 3;

	localparam logic [31:0] ISR_MAGIC     = 32'h5f375a86;
	localparam logic [31:0] QNAN_DEFAULT  = 32'hffc00000;
	localparam logic [31:0] QUIET_BIT     = 32'h00400000;
	localparam logic signed [11:0] EXP_BIAS = 12'sd127;
	localparam logic [23:0] SMAN_ONE_HALF = 24'hc00000;
	localparam logic [52:0] DMAN_ONE_HALF = 53'h18000000000000;

	// unpacked finite nonzero value: (-1)^sgn * 1.man * 2^exp
	typedef struct packed {
		logic               sgn;
		logic signed [11:0] exp;
		logic [23:0]        man;
	} fisn_num_t;

	// result decided by operand classes alone
	typedef struct packed {
		logic        hit;
		logic [31:0] bits;
	} fisn_spec_t;

	// values that travel with an item along the cell row
	typedef struct packed {
		logic [31:0] num;
		logic [31:0] xhalf;
		logic [31:0] y;
	} fisn_side_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (&b[30:23]) & (|b[22:0]);
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return (&b[30:23]) & ~(|b[22:0]);
	endfunction

	function automatic logic is_zero(input logic [31:0] b);
		return ~(|b[30:0]);
	endfunction

	function automatic logic [31:0] quiet(input logic [31:0] b);
		return b | QUIET_BIT;
	endfunction

	function automatic logic [4:0] lzc23(input logic [22:0] v);
		logic [4:0] n;
		logic       found;
		n     = 5'd0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 5'd1;
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd0;
		found = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 6'd1;
			end
		end
		return n;
	endfunction

	// normalize a finite nonzero single, subnormals included
	function automatic fisn_num_t unpack(input logic [31:0] b);
		fisn_num_t  r;
		logic [4:0] lz;
		lz    = lzc23(b[22:0]);
		r.sgn = b[31];
		if (b[30:23] == 8'd0) begin
			r.man = {1'b0, b[22:0]} << (lz + 5'd1);
			r.exp = -12'sd127 - $signed({7'd0, lz});
		end else begin
			r.man = {1'b1, b[22:0]};
			r.exp = $signed({4'd0, b[30:23]}) - EXP_BIAS;
		end
		return r;
	endfunction

	// round 1.m * 2^e to single, nearest even, with subnormals and overflow
	function automatic logic [31:0] round_single(input logic sgn,
		input logic signed [11:0] e, input logic [55:0] m, input logic st);
		logic signed [11:0] be;
		logic [5:0]         sh;
		logic [7:0]         ef;
		logic [111:0]       wide;
		logic [55:0]        ms;
		logic               lost;
		logic               g;
		logic               s;
		logic               rnd;
		logic [30:0]        mag;
		be = e + EXP_BIAS;
		if (be >= 12'sd1) begin
			sh = 6'd0;
			ef = be[7:0];
		end else begin
			ef = 8'd0;
			if (be < -12'sd61) sh = 6'd63;
			else sh = 6'(12'sd1 - be);
		end
		wide = {m, 56'd0} >> sh;
		ms   = wide[111:56];
		lost = |wide[55:0];
		g    = ms[31];
		s    = (|ms[30:0]) | lost | st;
		rnd  = g & (s | ms[32]);
		mag  = {ef, ms[54:32]} + {30'd0, rnd};
		if (be >= 12'sd255) return {sgn, 8'hff, 23'd0};
		return {sgn, mag};
	endfunction

	// single multiply outcome for nan, infinite and zero operands
	function automatic fisn_spec_t mul_special(input logic [31:0] a,
		input logic [31:0] b);
		fisn_spec_t r;
		logic       s;
		s      = a[31] ^ b[31];
		r.hit  = 1'b1;
		r.bits = {s, 31'd0};
		if (is_nan(a)) r.bits = quiet(a);
		else if (is_nan(b)) r.bits = quiet(b);
		else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
			r.bits = QNAN_DEFAULT;
		else if (is_inf(a) || is_inf(b)) r.bits = {s, 8'hff, 23'd0};
		else if (is_zero(a) || is_zero(b)) r.bits = {s, 31'd0};
		else r.hit = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/core/fisn_seed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisn_seed
// halves the operand and forms the magic-constant reciprocal root estimate
// ----------------------------------------------------------------------------
module fisn_seed (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            operand,
	output logic                   out_valid,
	output fisn_pkg::fisn_side_t   out_side
);

	fisn_pkg::fisn_num_t  n;
	fisn_pkg::fisn_side_t side_c;
	fisn_pkg::fisn_side_t side_s1;
	logic                 valid_s1;

	always_comb begin
		n            = fisn_pkg::unpack(operand);
		side_c.num   = operand;
		side_c.y     = fisn_pkg::ISR_MAGIC - {operand[31], operand[31:1]};
		if (fisn_pkg::is_nan(operand)) side_c.xhalf = fisn_pkg::quiet(operand);
		else if (fisn_pkg::is_inf(operand) || fisn_pkg::is_zero(operand))
			side_c.xhalf = operand;
		else
			side_c.xhalf = fisn_pkg::round_single(n.sgn, n.exp - 12'sd1,
				{n.man, 32'd0}, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) side_s1 <= side_c;
	end

	assign out_valid = valid_s1;
	assign out_side  = side_s1;

endmodule

>>> rtl/core/fisn_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisn_fmul
// three-stage single multiply, nearest even, sideband carried alongside
// ----------------------------------------------------------------------------
module fisn_fmul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            a,
	input  logic [31:0]            b,
	input  fisn_pkg::fisn_side_t   in_side,
	output logic                   out_valid,
	output logic [31:0]            out_bits,
	output fisn_pkg::fisn_side_t   out_side
);

	logic                 valid_s1, valid_s2, valid_s3;
	fisn_pkg::fisn_num_t  an_s1, bn_s1;
	fisn_pkg::fisn_spec_t spec_s1, spec_s2;
	fisn_pkg::fisn_side_t side_s1, side_s2, side_s3;
	logic [47:0]          prod_s2;
	logic                 sgn_s2;
	logic signed [11:0]   exp_s2;
	logic [31:0]          bits_s3;
	logic [55:0]          m_c;
	logic signed [11:0]   e_c;

	// product is in [1,4): one place of normalization at most
	always_comb begin
		if (prod_s2[47]) begin
			m_c = {prod_s2, 8'd0};
			e_c = exp_s2 + 12'sd1;
		end else begin
			m_c = {prod_s2[46:0], 9'd0};
			e_c = exp_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1   <= fisn_pkg::unpack(a);
			bn_s1   <= fisn_pkg::unpack(b);
			spec_s1 <= fisn_pkg::mul_special(a, b);
			side_s1 <= in_side;

			prod_s2 <= an_s1.man * bn_s1.man;
			sgn_s2  <= an_s1.sgn ^ bn_s1.sgn;
			exp_s2  <= an_s1.exp + bn_s1.exp;
			spec_s2 <= spec_s1;
			side_s2 <= side_s1;

			bits_s3 <= spec_s2.hit ? spec_s2.bits
				: fisn_pkg::round_single(sgn_s2, e_c, m_c, 1'b0);
			side_s3 <= side_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_bits  = bits_s3;
	assign out_side  = side_s3;

endmodule

>>> rtl/core/fisn_dstep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisn_dstep
// double-precision tail of a newton step: y * (1.5 - p), rounded to single
// ----------------------------------------------------------------------------
module fisn_dstep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            p_bits,
	input  fisn_pkg::fisn_side_t   in_side,
	output logic                   out_valid,
	output fisn_pkg::fisn_side_t   out_side
);

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic [31:0] bits;
	} fisn_pcls_t;

	localparam fisn_pkg::fisn_num_t ONE_HALF = '{sgn: 1'b0, exp: 12'sd0,
		man: fisn_pkg::SMAN_ONE_HALF};

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;

	fisn_pkg::fisn_side_t side_s1, side_s2, side_s3, side_s4;
	fisn_pkg::fisn_side_t side_s5, side_s6, side_s7, side_s8;
	fisn_pkg::fisn_num_t  yn_s1, yn_s2, yn_s3, yn_s4;
	fisn_pcls_t           pc_s1, pc_s2, pc_s3;
	fisn_pkg::fisn_spec_t spec_s5, spec_s6, spec_s7;

	fisn_pkg::fisn_num_t  q_s1;
	logic [55:0]          a_s2, b_s2;
	logic                 sub_s2, sgn_s2, sgn_s3;
	logic signed [11:0]   exp_s2, exp_s3;
	logic [56:0]          sum_s3;
	logic [5:0]           lz_s3;
	logic                 dsgn_s4;
	logic signed [11:0]   dexp_s4;
	logic [52:0]          dman_s4;
	fisn_pkg::fisn_spec_t spec_s4;
	logic [50:0]          pl_s5;
	logic [49:0]          ph_s5;
	logic                 sgn_s5, sgn_s6, sgn_s7;
	logic signed [11:0]   exp_s5, exp_s6, exp_s7;
	logic [76:0]          prod_s6;
	logic [52:0]          man_s7;

	// negated p and the new estimate, formed ahead of their registers
	fisn_pkg::fisn_num_t  pneg_c;
	fisn_pkg::fisn_side_t side8_c;

	always_comb begin
		pneg_c     = fisn_pkg::unpack(p_bits);
		pneg_c.sgn = ~p_bits[31];
	end

	always_comb begin
		side8_c   = side_s7;
		side8_c.y = spec_s7.hit ? spec_s7.bits
			: fisn_pkg::round_single(sgn_s7, exp_s7, {man_s7, 3'd0}, 1'b0);
	end

	// alignment of the smaller addend
	fisn_pkg::fisn_num_t  big_c, sml_c;
	logic                 qbig_c;
	logic signed [11:0]   diff_c;
	logic [5:0]           sh_c;
	logic [111:0]         wide_c;

	always_comb begin
		qbig_c = ($signed(q_s1.exp) > 12'sd0)
			|| (q_s1.exp == 12'sd0 && q_s1.man > fisn_pkg::SMAN_ONE_HALF);
		big_c  = qbig_c ? q_s1 : ONE_HALF;
		sml_c  = qbig_c ? ONE_HALF : q_s1;
		diff_c = big_c.exp - sml_c.exp;
		sh_c   = (diff_c > 12'sd63) ? 6'd63 : diff_c[5:0];
		wide_c = {sml_c.man, 88'd0} >> sh_c;
	end

	// normalize and round the difference to 53 bits
	logic [55:0]        nm_c;
	logic               nst_c;
	logic signed [11:0] ne_c;
	logic [53:0]        nr_c;
	logic               nrnd_c;
	logic               dzero_c;
	logic               dsgn_c;
	logic signed [11:0] dexp_c;
	logic [52:0]        dman_c;
	fisn_pkg::fisn_spec_t spec_c;
	logic               ysg_c;

	always_comb begin
		if (sum_s3[56]) begin
			nm_c  = sum_s3[56:1];
			nst_c = sum_s3[0];
			ne_c  = exp_s3 + 12'sd1;
		end else begin
			nm_c  = sum_s3[55:0] << lz_s3;
			nst_c = 1'b0;
			ne_c  = exp_s3 - $signed({6'd0, lz_s3});
		end
		nrnd_c = nm_c[2] & ((|nm_c[1:0]) | nst_c | nm_c[3]);
		nr_c   = {1'b0, nm_c[55:3]} + {53'd0, nrnd_c};
		if (nr_c[53]) begin
			dman_c = nr_c[53:1];
			dexp_c = ne_c + 12'sd1;
		end else begin
			dman_c = nr_c[52:0];
			dexp_c = ne_c;
		end
		dsgn_c = sgn_s3;
		// p of zero leaves exactly 1.5
		if (pc_s3.zero) begin
			dman_c = fisn_pkg::DMAN_ONE_HALF;
			dexp_c = 12'sd0;
			dsgn_c = 1'b0;
		end
		if (pc_s3.inf) dsgn_c = ~pc_s3.bits[31];
		dzero_c = (sum_s3 == 57'd0) & ~pc_s3.nan & ~pc_s3.inf & ~pc_s3.zero;
		if (dzero_c) dsgn_c = 1'b0;

		// y operand first when picking a nan
		ysg_c       = side_s3.y[31] ^ dsgn_c;
		spec_c.hit  = 1'b1;
		spec_c.bits = {ysg_c, 31'd0};
		if (fisn_pkg::is_nan(side_s3.y)) spec_c.bits = fisn_pkg::quiet(side_s3.y);
		else if (pc_s3.nan) spec_c.bits = fisn_pkg::quiet(pc_s3.bits);
		else if ((fisn_pkg::is_inf(side_s3.y) && dzero_c)
			|| (fisn_pkg::is_zero(side_s3.y) && pc_s3.inf))
			spec_c.bits = fisn_pkg::QNAN_DEFAULT;
		else if (fisn_pkg::is_inf(side_s3.y) || pc_s3.inf)
			spec_c.bits = {ysg_c, 8'hff, 23'd0};
		else if (fisn_pkg::is_zero(side_s3.y) || dzero_c)
			spec_c.bits = {ysg_c, 31'd0};
		else spec_c.hit = 1'b0;
	end

	// round the 77-bit product to double
	logic [52:0]        pk_c;
	logic               pg_c, ps_c;
	logic signed [11:0] pe_c;
	logic [53:0]        pr_c;

	always_comb begin
		if (prod_s6[76]) begin
			pk_c = prod_s6[76:24];
			pg_c = prod_s6[23];
			ps_c = |prod_s6[22:0];
			pe_c = exp_s6 + 12'sd1;
		end else begin
			pk_c = prod_s6[75:23];
			pg_c = prod_s6[22];
			ps_c = |prod_s6[21:0];
			pe_c = exp_s6;
		end
		pr_c = {1'b0, pk_c} + {53'd0, pg_c & (ps_c | pk_c[0])};
		if (pr_c[53]) pe_c = pe_c + 12'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: unpack, negate p
			q_s1      <= pneg_c;
			pc_s1     <= '{nan: fisn_pkg::is_nan(p_bits), inf: fisn_pkg::is_inf(p_bits),
				zero: fisn_pkg::is_zero(p_bits), bits: p_bits};
			yn_s1     <= fisn_pkg::unpack(in_side.y);
			side_s1   <= in_side;

			// s2: align
			a_s2   <= {big_c.man, 32'd0};
			b_s2   <= {wide_c[111:57], wide_c[56] | (|wide_c[55:0])};
			sub_s2 <= big_c.sgn ^ sml_c.sgn;
			sgn_s2 <= big_c.sgn;
			exp_s2 <= big_c.exp;
			pc_s2  <= pc_s1;
			yn_s2  <= yn_s1;
			side_s2 <= side_s1;

			// s3: add or subtract
			sum_s3 <= sub_s2 ? ({1'b0, a_s2} - {1'b0, b_s2})
				: ({1'b0, a_s2} + {1'b0, b_s2});
			lz_s3  <= fisn_pkg::lzc56(sub_s2 ? (a_s2 - b_s2) : (a_s2 + b_s2));
			sgn_s3 <= sgn_s2;
			exp_s3 <= exp_s2;
			pc_s3  <= pc_s2;
			yn_s3  <= yn_s2;
			side_s3 <= side_s2;

			// s4: normalize, round to double
			dsgn_s4 <= dsgn_c;
			dexp_s4 <= dexp_c;
			dman_s4 <= dman_c;
			spec_s4 <= spec_c;
			yn_s4   <= yn_s3;
			side_s4 <= side_s3;

			// s5: partial products
			pl_s5   <= yn_s4.man * dman_s4[26:0];
			ph_s5   <= yn_s4.man * dman_s4[52:27];
			sgn_s5  <= yn_s4.sgn ^ dsgn_s4;
			exp_s5  <= yn_s4.exp + dexp_s4;
			spec_s5 <= spec_s4;
			side_s5 <= side_s4;

			// s6: combine
			prod_s6 <= {ph_s5, 27'd0} + {26'd0, pl_s5};
			sgn_s6  <= sgn_s5;
			exp_s6  <= exp_s5;
			spec_s6 <= spec_s5;
			side_s6 <= side_s5;

			// s7: round product to double
			man_s7  <= pr_c[53] ? pr_c[53:1] : pr_c[52:0];
			exp_s7  <= pe_c;
			sgn_s7  <= sgn_s6;
			spec_s7 <= spec_s6;
			side_s7 <= side_s6;

			// s8: round to single, new estimate
			side_s8 <= side8_c;
		end
	end

	assign out_valid = valid_s8;
	assign out_side  = side_s8;

endmodule

>>> rtl/core/fisn_newton.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisn_newton
// one newton cell: p = xhalf*y*y in single, then y * (1.5 - p) in double
// ----------------------------------------------------------------------------
module fisn_newton (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  fisn_pkg::fisn_side_t   in_side,
	output logic                   out_valid,
	output fisn_pkg::fisn_side_t   out_side
);

	logic                 v1, v2;
	logic [31:0]          p1, p2;
	fisn_pkg::fisn_side_t side1, side2;

	fisn_fmul u_mul_xy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .a(in_side.xhalf), .b(in_side.y), .in_side(in_side),
		.out_valid(v1), .out_bits(p1), .out_side(side1)
	);

	fisn_fmul u_mul_py (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v1), .a(p1), .b(side1.y), .in_side(side1),
		.out_valid(v2), .out_bits(p2), .out_side(side2)
	);

	fisn_dstep u_dstep (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v2), .p_bits(p2), .in_side(side2),
		.out_valid(out_valid), .out_side(out_side)
	);

endmodule

>>> rtl/core/fast_inverse_sqrt_newton_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_newton_top
// approximate single-precision square root via the magic-constant estimate
// ----------------------------------------------------------------------------
// usage:
//   operand channel: operand_bits beats with operand_valid / operand_ready
//   root channel:    root_bits beats with root_valid / root_ready
//   each operand beat yields exactly one root beat, in order
// pipeline:
//   from accept to root_valid: the seed register, three newton cells (each
//   two 3-stage single multiplies plus an 8-stage double tail), the final
//   single multiply by the operand, 1 output register; every stage is a full
//   pipeline stage, and throughput is one beat per cycle unless the row holds
// stalls:
//   the row of cells moves while its last stage is empty or the output
//   register can take a beat, so operands keep flowing into bubbles while a
//   root waits; with the row full and root_ready low everything holds
// reset:
//   arst_n clears all valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_newton_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        operand_valid,
	output logic        operand_ready,
	input  logic [31:0] operand_bits,
	output logic        root_valid,
	input  logic        root_ready,
	output logic [31:0] root_bits
);

	localparam int STEPS = fisn_pkg::NEWTON_STEPS;

	// cell row links: entry 0 is the seed output
	logic                 chain_valid [STEPS+1];
	fisn_pkg::fisn_side_t chain_side  [STEPS+1];

	logic                 fin_valid;
	logic [31:0]          fin_bits;
	fisn_pkg::fisn_side_t fin_side;

	logic        out_load;
	logic        en;
	logic        root_valid_q;
	logic [31:0] root_bits_q;

	// output register takes a beat when empty or being drained
	assign out_load = !root_valid_q || root_ready;
	// the row advances when its last stage is a bubble or can hand off
	assign en            = !fin_valid || out_load;
	assign operand_ready = en;

	fisn_seed u_seed (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(operand_valid), .operand(operand_bits),
		.out_valid(chain_valid[0]), .out_side(chain_side[0])
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		fisn_newton u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(chain_valid[k]), .in_side(chain_side[k]),
			.out_valid(chain_valid[k+1]), .out_side(chain_side[k+1])
		);
	end

	// final estimate times the operand
	fisn_fmul u_final (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(chain_valid[STEPS]),
		.a(chain_side[STEPS].y), .b(chain_side[STEPS].num),
		.in_side(chain_side[STEPS]),
		.out_valid(fin_valid), .out_bits(fin_bits), .out_side(fin_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_valid_q <= 1'b0;
		else if (out_load) root_valid_q <= fin_valid;
	end

	// sideband is dropped here; only the rounded root leaves
	always_ff @(posedge clk) begin
		if (out_load && fin_valid) root_bits_q <= fin_side.num[31] & 1'b0 | fin_bits[31]
			? fin_bits : fin_bits;
	end

	assign root_valid = root_valid_q;
	assign root_bits  = root_bits_q;

endmodule
